// ===== src/ile_pkg.sv =====
// Shared constants, operation codes and cell command types for the indexed list engine.
package ile_pkg;

  // Default number of list entries
  localparam int ILE_CAPACITY = 64;

  // Payload widths fixed by the channel definition
  localparam int OPCODE_W = 3;
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // Operation codes
  localparam logic [OPCODE_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_POP    = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_GET    = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BOUNDS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  // What every cell does on a clock edge
  typedef enum logic [1:0] {
    CELL_HOLD     = 2'd0,
    CELL_WRITE    = 2'd1,
    CELL_SHIFT_UP = 2'd2,
    CELL_SHIFT_DN = 2'd3
  } cell_kind_t;

  // Command broadcast along the row of cells
  typedef struct packed {
    cell_kind_t        kind;
    logic [DATA_W-1:0] value;
    logic              rd_en;
  } cell_cmd_t;

endpackage

// ===== src/ile_if.sv =====
// Valid/ready channel interfaces for list operations and their results.
interface ile_in_if import ile_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic        [OPCODE_W-1:0] opcode;
  logic        [POS_W-1:0]    position;
  logic signed [DATA_W-1:0]   value;

  modport source (output valid, output opcode, output position, output value, input ready);
  modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

interface ile_out_if import ile_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [DATA_W-1:0]   read_value;
  logic        [STATUS_W-1:0] status;
  logic        [COUNT_W-1:0]  count;

  modport source (output valid, output read_value, output status, output count, input ready);
  modport sink   (input valid, input read_value, input status, input count, output ready);
endinterface

// ===== src/ile_cell.sv =====
// One list entry: holds a word, loads a written or inserted value, and takes its neighbor's word on a shift.
module ile_cell import ile_pkg::*; #(
  parameter int IDX_W = 7,
  parameter int IDX   = 0
) (
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [IDX_W-1:0]  tgt_idx,
  input  logic [IDX_W-1:0]  rd_idx,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  output logic [DATA_W-1:0] data,
  output logic [DATA_W-1:0] rd_data
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  // Next word for this slot
  always_comb begin
    data_nxt = data_r;
    case (cmd.kind)
      CELL_WRITE: begin
        if (tgt_idx == MY_IDX) data_nxt = cmd.value;
      end
      CELL_SHIFT_UP: begin
        if (MY_IDX > tgt_idx) data_nxt = left_data;
        else if (MY_IDX == tgt_idx) data_nxt = cmd.value;
      end
      CELL_SHIFT_DN: begin
        if (MY_IDX >= tgt_idx) data_nxt = right_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  // Drive the shared read bus only when selected
  assign rd_data = (cmd.rd_en && (rd_idx == MY_IDX)) ? data_r : '0;

endmodule

// ===== src/ile_chain.sv =====
// Row of entry cells with neighbor links and a wired-OR read bus.
module ile_chain import ile_pkg::*; #(
  parameter int CAPACITY = ILE_CAPACITY,
  parameter int IDX_W    = 7
) (
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [IDX_W-1:0]  tgt_idx,
  input  logic [IDX_W-1:0]  rd_idx,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] cell_rd   [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_w;
    logic [DATA_W-1:0] right_w;

    // End cells loop back on themselves; only the last is ever selected
    if (i == 0) begin : g_first
      assign left_w = cell_data[0];
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = cell_data[i];
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end

    ile_cell #(
      .IDX_W (IDX_W),
      .IDX   (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .tgt_idx    (tgt_idx),
      .rd_idx     (rd_idx),
      .left_data  (left_w),
      .right_data (right_w),
      .data       (cell_data[i]),
      .rd_data    (cell_rd[i])
    );
  end

  // At most one cell drives a nonzero word
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_data = rd_data | cell_rd[i];
    end
  end

endmodule

// ===== src/indexed_list_engine.sv =====
// Indexed list engine: results are registered on transfer and appear the cycle after.
// Throughput is one operation per cycle while out_ch.ready holds; addressed cells shift
// or write in the transfer cycle and the result register frees itself when taken.
// A new operation is taken while the output register is empty or being drained.
// Reset (synchronous, active low) clears the length and the output valid; entry
// words are not cleared and no clearing pass runs.
module indexed_list_engine import ile_pkg::*; #(
  parameter int CAPACITY = ILE_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  ile_in_if.sink    in_ch,
  ile_out_if.source out_ch
);

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0]       cnt_r;
  logic [CW-1:0]       cnt_nxt;
  logic                out_valid_r;
  logic [DATA_W-1:0]   read_value_r;
  logic [STATUS_W-1:0] status_r;
  logic [COUNT_W-1:0]  count_r;

  logic                in_fire;
  logic                full;
  logic [IDX_W-1:0]    pos_x;
  logic [IDX_W-1:0]    cnt_x;
  logic [IDX_W-1:0]    cnt_nxt_x;
  logic [IDX_W-1:0]    tgt_idx;
  logic [IDX_W-1:0]    rd_idx;
  logic [STATUS_W-1:0] st_nxt;
  logic [DATA_W-1:0]   rd_bus;
  cell_cmd_t           cmd;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign full        = (cnt_r == CW'(CAPACITY));
  assign pos_x       = IDX_W'(in_ch.position);
  assign cnt_x       = IDX_W'(cnt_r);
  assign cnt_nxt_x   = IDX_W'(cnt_nxt);

  // Operation decode and bounds checks
  always_comb begin
    cmd.kind  = CELL_HOLD;
    cmd.value = in_ch.value;
    cmd.rd_en = 1'b0;
    tgt_idx   = pos_x;
    rd_idx    = pos_x;
    st_nxt    = ST_OK;
    cnt_nxt   = cnt_r;
    case (in_ch.opcode)
      OP_PUSH: begin
        if (full) begin
          st_nxt = ST_FULL;
        end else begin
          cmd.kind = CELL_WRITE;
          tgt_idx  = cnt_x;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      OP_POP: begin
        if (cnt_r == '0) begin
          st_nxt = ST_BOUNDS;
        end else begin
          cmd.rd_en = 1'b1;
          rd_idx    = cnt_x - 1'b1;
          cnt_nxt   = cnt_r - 1'b1;
        end
      end
      OP_INSERT: begin
        if (pos_x > cnt_x) begin
          st_nxt = ST_BOUNDS;
        end else if (full) begin
          st_nxt = ST_FULL;
        end else begin
          cmd.kind = CELL_SHIFT_UP;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (pos_x >= cnt_x) begin
          st_nxt = ST_BOUNDS;
        end else begin
          cmd.kind = CELL_SHIFT_DN;
          cnt_nxt  = cnt_r - 1'b1;
        end
      end
      OP_GET: begin
        if (pos_x >= cnt_x) begin
          st_nxt = ST_BOUNDS;
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      default: ;
    endcase
    // Cells change only on a transfer
    if (!in_fire) begin
      cmd.kind = CELL_HOLD;
    end
  end

  ile_chain #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W)
  ) u_chain (
    .clk     (clk),
    .cmd     (cmd),
    .tgt_idx (tgt_idx),
    .rd_idx  (rd_idx),
    .rd_data (rd_bus)
  );

  // Length and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        cnt_r <= cnt_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      read_value_r <= cmd.rd_en ? rd_bus : '0;
      status_r     <= st_nxt;
      count_r      <= cnt_nxt_x[COUNT_W-1:0];
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = read_value_r;
  assign out_ch.status     = status_r;
  assign out_ch.count      = count_r;

  // Length stays within the store
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(CAPACITY))
    else $error("list length exceeds capacity");

  // A successful push grows the list by one
  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_ch.opcode == OP_PUSH) && (st_nxt == ST_OK))
    |=> (cnt_r == CW'($past(cnt_r) + 1'b1)))
    else $error("push did not grow the list");

  // A failed operation returns no data
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r != ST_OK)) |-> (read_value_r == '0))
    else $error("failed operation returned data");

  // A failed operation leaves the length alone
  a_fail_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (st_nxt != ST_OK)) |=> $stable(cnt_r))
    else $error("failed operation changed the length");

endmodule
